>>> rtl/core/lrmp_pkg.sv
// Shared constants and types for the linear recurrence modulo prime unit.
// Used by lrmp_mac_lane and linear_recurrence_mod_prime_unit; depends on nothing.
package lrmp_pkg;

  // Width of the input words and of the reduced residues.
  localparam int OP_W  = 32;
  localparam int RES_W = 30;

  // Number of exponent bits scanned; term_index is masked to this width.
  localparam int INDEX_BITS = 32;
  localparam int BIT_CNT_W  = $clog2(INDEX_BITS);

  // One bit of the shifting operand is consumed per step.
  localparam int STEPS      = RES_W;
  localparam int STEP_CNT_W = $clog2(STEPS);

  // A 32-bit input is below 4.3 times the prime, so four conditional
  // subtractions fully reduce it.
  localparam int RED_PASSES = 4;
  localparam int RED_CNT_W  = $clog2(RED_PASSES);

  localparam logic [OP_W-1:0] PRIME    = 32'd1000000007;
  localparam logic [OP_W-1:0] PRIME_X2 = 32'd2000000014;
  localparam logic [OP_W-1:0] PRIME_X3 = 32'd3000000021;

  // Control group driven by the sequencer into every lane.
  typedef struct packed {
    logic load;
    logic step;
  } lane_ctrl_t;

endpackage

>>> rtl/core/lrmp_mac_lane.sv
// Bit-serial modular dot product a0*b0 + a1*b1 mod p, one bit of a per cycle while step is high.
// Depends on lrmp_pkg.
module lrmp_mac_lane (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  lrmp_pkg::lane_ctrl_t      ctrl_i,
  input  logic [lrmp_pkg::RES_W-1:0] a0_i,
  input  logic [lrmp_pkg::RES_W-1:0] a1_i,
  input  logic [lrmp_pkg::RES_W-1:0] b0_i,
  input  logic [lrmp_pkg::RES_W-1:0] b1_i,
  output logic [lrmp_pkg::RES_W-1:0] sum_o
);

  logic [lrmp_pkg::RES_W-1:0] a0_sh_q, a1_sh_q, b0_q, b1_q;
  logic [lrmp_pkg::RES_W-1:0] acc_q, acc_d;
  logic [lrmp_pkg::OP_W-1:0]  dbl, pp0, pp1, raw, red;

  // Horner step, most significant bit first: acc = 2*acc + bits*b, kept below p.
  // With acc < p the raw sum stays below 4p, so one of three subtractions suffices.
  always_comb begin
    dbl = {1'b0, acc_q, 1'b0};
    pp0 = a0_sh_q[lrmp_pkg::RES_W-1] ? {2'b00, b0_q} : '0;
    pp1 = a1_sh_q[lrmp_pkg::RES_W-1] ? {2'b00, b1_q} : '0;
    raw = dbl + pp0 + pp1;
    priority if (raw >= lrmp_pkg::PRIME_X3) begin
      red = raw - lrmp_pkg::PRIME_X3;
    end else if (raw >= lrmp_pkg::PRIME_X2) begin
      red = raw - lrmp_pkg::PRIME_X2;
    end else if (raw >= lrmp_pkg::PRIME) begin
      red = raw - lrmp_pkg::PRIME;
    end else begin
      red = raw;
    end
    acc_d = red[lrmp_pkg::RES_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else if (ctrl_i.load) begin
      acc_q <= '0;
    end else if (ctrl_i.step) begin
      acc_q <= acc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      a0_sh_q <= a0_i;
      a1_sh_q <= a1_i;
      b0_q    <= b0_i;
      b1_q    <= b1_i;
    end else if (ctrl_i.step) begin
      a0_sh_q <= {a0_sh_q[lrmp_pkg::RES_W-2:0], 1'b0};
      a1_sh_q <= {a1_sh_q[lrmp_pkg::RES_W-2:0], 1'b0};
    end
  end

  assign sum_o = acc_q;

endmodule

>>> rtl/core/linear_recurrence_mod_prime_unit.sv
// Top level: term n of a(k) = x*a(k-1) + y*a(k-2) mod 1000000007 by 2x2 matrix powering.
// Depends on lrmp_pkg and lrmp_mac_lane (four bit-serial lanes, one per matrix entry).
//
// Channel   Direction  Handshake          Word
// command   in         start / busy       first_term, second_term, coef_prev,
//                                         coef_prev2, term_index
// result    out        done_o (strobe)    term_value_o
//
// A word is taken at a clock edge with start high and busy low; busy then stays
// high until the result strobe. An index of two or less returns the reduced first
// or second term after the reduction passes, with no matrix product. Otherwise,
// for each bit of n-2 below its leading one, the block squares and then multiplies
// by the base if that bit is one, and lane zero forms the closing dot product;
// each matrix product takes 30 steps of the bit-serial lanes. The result is shown for one cycle only.
// Reset is asynchronous, active low, and returns the block to idle.
module linear_recurrence_mod_prime_unit (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  output logic                       busy,
  input  logic [lrmp_pkg::OP_W-1:0]  first_term_i,
  input  logic [lrmp_pkg::OP_W-1:0]  second_term_i,
  input  logic [lrmp_pkg::OP_W-1:0]  coef_prev_i,
  input  logic [lrmp_pkg::OP_W-1:0]  coef_prev2_i,
  input  logic [lrmp_pkg::OP_W-1:0]  term_index_i,
  output logic                       done_o,
  output logic [lrmp_pkg::RES_W-1:0] term_value_o
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_REDUCE = 4'd1;
  localparam logic [3:0] S_SETUP  = 4'd2;
  localparam logic [3:0] S_BIT    = 4'd3;
  localparam logic [3:0] S_SQ     = 4'd4;
  localparam logic [3:0] S_SQ_WB  = 4'd5;
  localparam logic [3:0] S_MLOAD  = 4'd6;
  localparam logic [3:0] S_MUL    = 4'd7;
  localparam logic [3:0] S_MUL_WB = 4'd8;
  localparam logic [3:0] S_FLOAD  = 4'd9;
  localparam logic [3:0] S_FIN    = 4'd10;
  localparam logic [3:0] S_FOUT   = 4'd11;

  localparam int IW = lrmp_pkg::INDEX_BITS;
  localparam int RW = lrmp_pkg::RES_W;

  logic [3:0] state_q, state_d;
  logic [lrmp_pkg::RED_CNT_W-1:0]  red_cnt_q, red_cnt_d;
  logic [lrmp_pkg::STEP_CNT_W-1:0] step_cnt_q, step_cnt_d;
  logic [lrmp_pkg::BIT_CNT_W-1:0]  bit_q, bit_d;
  logic started_q, started_d;
  logic done_q, done_d;

  // Operands in order a1, a2, x, y; reduced in place.
  logic [lrmp_pkg::OP_W-1:0] op_q [4];
  logic [lrmp_pkg::OP_W-1:0] op_d [4];
  logic [IW-1:0]             idx_q, idx_d, idx_in;
  logic [IW-1:0]             exp_q, exp_d;
  logic [IW+lrmp_pkg::OP_W-1:0] idx_ext;
  logic [RW-1:0] acc_q [4];
  logic [RW-1:0] acc_d [4];
  logic [RW-1:0] base_q [4];
  logic [RW-1:0] base_d [4];
  logic [RW-1:0] mat_b [4];
  logic [RW-1:0] lane_sum [4];
  logic [RW-1:0] value_q, value_d;

  lrmp_pkg::lane_ctrl_t lane_ctrl;
  logic sel_base, fin_sel, last_step;

  assign idx_ext   = {{IW{1'b0}}, term_index_i};
  assign idx_in    = idx_ext[IW-1:0];
  assign busy      = (state_q != S_IDLE);
  assign last_step = (step_cnt_q == lrmp_pkg::STEP_CNT_W'(lrmp_pkg::STEPS - 1));
  assign sel_base  = (state_q == S_MLOAD);
  assign fin_sel   = (state_q == S_FLOAD);

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      mat_b[i] = sel_base ? base_q[i] : acc_q[i];
    end
  end

  for (genvar g = 0; g < 4; g++) begin : g_lane
    logic [RW-1:0] b0, b1;
    if (g == 0) begin : g_fin
      // Lane zero also forms the closing dot product acc0*a2 + acc1*a1.
      assign b0 = fin_sel ? op_q[1][RW-1:0] : mat_b[0];
      assign b1 = fin_sel ? op_q[0][RW-1:0] : mat_b[2];
    end else begin : g_mat
      assign b0 = mat_b[g % 2];
      assign b1 = mat_b[(g % 2) + 2];
    end
    lrmp_mac_lane u_lane (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctrl_i (lane_ctrl),
      .a0_i   (acc_q[(g / 2) * 2]),
      .a1_i   (acc_q[(g / 2) * 2 + 1]),
      .b0_i   (b0),
      .b1_i   (b1),
      .sum_o  (lane_sum[g])
    );
  end

  always_comb begin
    state_d    = state_q;
    red_cnt_d  = red_cnt_q;
    step_cnt_d = step_cnt_q;
    bit_d      = bit_q;
    started_d  = started_q;
    done_d     = 1'b0;
    idx_d      = idx_q;
    exp_d      = exp_q;
    value_d    = value_q;
    op_d       = op_q;
    acc_d      = acc_q;
    base_d     = base_q;
    lane_ctrl  = '0;

    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          op_d[0]   = first_term_i;
          op_d[1]   = second_term_i;
          op_d[2]   = coef_prev_i;
          op_d[3]   = coef_prev2_i;
          idx_d     = idx_in;
          red_cnt_d = '0;
          state_d   = S_REDUCE;
        end
      end
      S_REDUCE: begin
        for (int i = 0; i < 4; i++) begin
          if (op_q[i] >= lrmp_pkg::PRIME) begin
            op_d[i] = op_q[i] - lrmp_pkg::PRIME;
          end
        end
        red_cnt_d = red_cnt_q + 1'b1;
        if (red_cnt_q == lrmp_pkg::RED_CNT_W'(lrmp_pkg::RED_PASSES - 1)) begin
          state_d = S_SETUP;
        end
      end
      S_SETUP: begin
        base_d[0] = op_q[2][RW-1:0];
        base_d[1] = op_q[3][RW-1:0];
        base_d[2] = RW'(1);
        base_d[3] = '0;
        exp_d     = idx_q - IW'(2);
        bit_d     = lrmp_pkg::BIT_CNT_W'(IW - 1);
        started_d = 1'b0;
        if (idx_q < IW'(2)) begin
          value_d = op_q[0][RW-1:0];
          done_d  = 1'b1;
          state_d = S_IDLE;
        end else if (idx_q == IW'(2)) begin
          value_d = op_q[1][RW-1:0];
          done_d  = 1'b1;
          state_d = S_IDLE;
        end else begin
          state_d = S_BIT;
        end
      end
      S_BIT: begin
        if (started_q) begin
          lane_ctrl.load = 1'b1;
          step_cnt_d     = '0;
          state_d        = S_SQ;
        end else begin
          // Until the leading one the accumulator stands for the identity; at the leading one it takes the base.
          if (exp_q[bit_q]) begin
            acc_d     = base_q;
            started_d = 1'b1;
          end
          if (bit_q == '0) begin
            state_d = S_FLOAD;
          end else begin
            bit_d   = bit_q - 1'b1;
            state_d = S_BIT;
          end
        end
      end
      S_SQ, S_MUL, S_FIN: begin
        lane_ctrl.step = 1'b1;
        step_cnt_d     = step_cnt_q + 1'b1;
        if (last_step) begin
          step_cnt_d = '0;
          unique case (state_q)
            S_SQ:    state_d = S_SQ_WB;
            S_MUL:   state_d = S_MUL_WB;
            default: state_d = S_FOUT;
          endcase
        end
      end
      S_SQ_WB: begin
        acc_d = lane_sum;
        if (exp_q[bit_q]) begin
          state_d = S_MLOAD;
        end else if (bit_q == '0) begin
          state_d = S_FLOAD;
        end else begin
          bit_d   = bit_q - 1'b1;
          state_d = S_BIT;
        end
      end
      S_MLOAD: begin
        lane_ctrl.load = 1'b1;
        step_cnt_d     = '0;
        state_d        = S_MUL;
      end
      S_MUL_WB: begin
        acc_d = lane_sum;
        if (bit_q == '0) begin
          state_d = S_FLOAD;
        end else begin
          bit_d   = bit_q - 1'b1;
          state_d = S_BIT;
        end
      end
      S_FLOAD: begin
        lane_ctrl.load = 1'b1;
        step_cnt_d     = '0;
        state_d        = S_FIN;
      end
      S_FOUT: begin
        value_d = lane_sum[0];
        done_d  = 1'b1;
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      red_cnt_q  <= '0;
      step_cnt_q <= '0;
      bit_q      <= '0;
      started_q  <= 1'b0;
      done_q     <= 1'b0;
    end else begin
      state_q    <= state_d;
      red_cnt_q  <= red_cnt_d;
      step_cnt_q <= step_cnt_d;
      bit_q      <= bit_d;
      started_q  <= started_d;
      done_q     <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q    <= op_d;
    idx_q   <= idx_d;
    exp_q   <= exp_d;
    acc_q   <= acc_d;
    base_q  <= base_d;
    value_q <= value_d;
  end

  assign done_o       = done_q;
  assign term_value_o = value_q;

  a_result_reduced: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> ({2'b00, term_value_o} < lrmp_pkg::PRIME))
    else $error("result word is not reduced below the prime");

  a_single_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe lasted more than one cycle");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("accepted command word did not raise busy");

  a_step_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lane_ctrl.step |-> (step_cnt_q < lrmp_pkg::STEP_CNT_W'(lrmp_pkg::STEPS)))
    else $error("lane step counter ran past the operand width");

endmodule

>>> test/tb.sv
// Testbench for linear_recurrence_mod_prime_unit: directed and random term requests.
// Each result is checked against a matrix-power predictor of the recurrence mod 1000000007.
// Depends on lrmp_pkg and the unit under test.
`timescale 1ns / 1ps

module tb;
  import lrmp_pkg::*;

  localparam longint unsigned MODULUS = 64'(PRIME);
  localparam logic [OP_W-1:0] ALL_ONES = '1;

  typedef struct packed {
    logic [63:0] m00;
    logic [63:0] m01;
    logic [63:0] m10;
    logic [63:0] m11;
  } mat2_t;

  logic             clk_i;
  logic             rst_ni;
  logic             start;
  logic             busy;
  logic [OP_W-1:0]  first_term_i;
  logic [OP_W-1:0]  second_term_i;
  logic [OP_W-1:0]  coef_prev_i;
  logic [OP_W-1:0]  coef_prev2_i;
  logic [OP_W-1:0]  term_index_i;
  logic             done_o;
  logic [RES_W-1:0] term_value_o;

  logic [RES_W-1:0] pending_terms[$];
  logic [RES_W-1:0] wanted_term;
  int               errors;

  linear_recurrence_mod_prime_unit dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .first_term_i (first_term_i),
    .second_term_i(second_term_i),
    .coef_prev_i  (coef_prev_i),
    .coef_prev2_i (coef_prev2_i),
    .term_index_i (term_index_i),
    .done_o       (done_o),
    .term_value_o (term_value_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic logic [63:0] mul_mod(input logic [63:0] a, input logic [63:0] b);
    return ((a % MODULUS) * (b % MODULUS)) % MODULUS;
  endfunction

  function automatic mat2_t mat_product(input mat2_t a, input mat2_t b);
    mat2_t r;
    r.m00 = (mul_mod(a.m00, b.m00) + mul_mod(a.m01, b.m10)) % MODULUS;
    r.m01 = (mul_mod(a.m00, b.m01) + mul_mod(a.m01, b.m11)) % MODULUS;
    r.m10 = (mul_mod(a.m10, b.m00) + mul_mod(a.m11, b.m10)) % MODULUS;
    r.m11 = (mul_mod(a.m10, b.m01) + mul_mod(a.m11, b.m11)) % MODULUS;
    return r;
  endfunction

  // Term n of a(k) = x*a(k-1) + y*a(k-2), from the top row of [[x,y],[1,0]]^(n-2).
  function automatic logic [RES_W-1:0] recurrence_term(input logic [OP_W-1:0] a1_w,
                                                       input logic [OP_W-1:0] a2_w,
                                                       input logic [OP_W-1:0] x_w,
                                                       input logic [OP_W-1:0] y_w,
                                                       input logic [OP_W-1:0] n_w);
    logic [63:0] a1, a2, n, e, idx_mask, term;
    mat2_t       step_mat, power;
    a1 = 64'(a1_w) % MODULUS;
    a2 = 64'(a2_w) % MODULUS;
    idx_mask = (INDEX_BITS >= 64) ? '1 : ((64'd1 << INDEX_BITS) - 64'd1);
    n = 64'(n_w) & idx_mask;
    if (n <= 64'd1) return a1[RES_W-1:0];
    if (n == 64'd2) return a2[RES_W-1:0];
    e = n - 64'd2;
    step_mat = '{m00: 64'(x_w) % MODULUS, m01: 64'(y_w) % MODULUS, m10: 64'd1, m11: 64'd0};
    power = '{m00: 64'd1, m01: 64'd0, m10: 64'd0, m11: 64'd1};
    for (int b = INDEX_BITS - 1; b >= 0; b--) begin
      power = mat_product(power, power);
      if (e[b]) power = mat_product(power, step_mat);
    end
    term = (mul_mod(power.m00, a2) + mul_mod(power.m01, a1)) % MODULUS;
    return term[RES_W-1:0];
  endfunction

  // Presents one word; start drops at random while waiting, so gaps land on every phase.
  task automatic send_term_request(input logic [OP_W-1:0] a1, input logic [OP_W-1:0] a2,
                                   input logic [OP_W-1:0] x, input logic [OP_W-1:0] y,
                                   input logic [OP_W-1:0] n, input int idle_pct);
    logic offered;
    first_term_i  <= a1;
    second_term_i <= a2;
    coef_prev_i   <= x;
    coef_prev2_i  <= y;
    term_index_i  <= n;
    forever begin
      offered = ($urandom_range(99) >= idle_pct);
      start <= offered;
      @(posedge clk_i);
      if (offered && !busy) break;
    end
    pending_terms.push_back(recurrence_term(a1, a2, x, y, n));
  endtask

  // Every result strobe must match the oldest outstanding request.
  always @(posedge clk_i) begin
    if (rst_ni && done_o === 1'b1) begin
      if (pending_terms.size() == 0) begin
        $error("term_value_o: no result expected, got %0d", term_value_o);
        errors++;
      end else begin
        wanted_term = pending_terms.pop_front();
        if (term_value_o !== wanted_term) begin
          $error("term_value_o: expected %0d, got %0d", wanted_term, term_value_o);
          errors++;
        end
      end
    end
  end

  function automatic logic [OP_W-1:0] pick_operand();
    case ($urandom_range(9))
      0:       return '0;
      1:       return ALL_ONES - OP_W'($urandom_range(3));
      2:       return PRIME - OP_W'($urandom_range(2)) + OP_W'($urandom_range(2));
      3:       return PRIME_X2 + OP_W'($urandom_range(1));
      4:       return OP_W'($urandom_range(16));
      default: return $urandom();
    endcase
  endfunction

  // Mostly short indexes keep the run short; full-width ones exercise every index bit.
  function automatic logic [OP_W-1:0] pick_index();
    case ($urandom_range(19))
      0:       return OP_W'($urandom_range(3));
      1, 2:    return $urandom();
      3, 4:    return ALL_ONES - OP_W'($urandom_range(1, 2)) + 32'd1;
      5, 6, 7: return OP_W'($urandom_range(1, 65535));
      default: return OP_W'($urandom_range(3, 64));
    endcase
  endfunction

  // Index zero behaves like index one; one and two return the reduced start terms.
  task automatic test_low_indexes();
    send_term_request(ALL_ONES, ALL_ONES, 32'd5, 32'd7, 32'd0, 10);
    send_term_request(ALL_ONES, PRIME, 32'd5, 32'd7, 32'd1, 10);
    send_term_request(PRIME, ALL_ONES, 32'd5, 32'd7, 32'd2, 10);
    send_term_request(PRIME - 32'd1, PRIME + 32'd1, ALL_ONES, ALL_ONES, 32'd1, 10);
    send_term_request(32'd0, PRIME - 32'd1, ALL_ONES, ALL_ONES, 32'd2, 10);
    send_term_request(PRIME_X3, 32'd0, 32'd0, 32'd0, 32'd0, 10);
  endtask

  // Largest operands, zero coefficients and extreme indexes.
  task automatic test_operand_extremes();
    send_term_request(ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES, 32'd3, 0);
    send_term_request(PRIME - 32'd1, PRIME - 32'd1, PRIME - 32'd1, PRIME - 32'd1, 32'd3, 0);
    send_term_request(PRIME, PRIME, PRIME, PRIME, 32'd4, 0);
    send_term_request(32'd1, 32'd1, 32'd1, 32'd1, 32'd10, 0);
    send_term_request(32'd3, 32'd9, 32'd0, 32'd4, 32'd7, 0);
    send_term_request(32'd3, 32'd9, 32'd4, 32'd0, 32'd7, 0);
    send_term_request(32'd0, 32'd0, ALL_ONES, ALL_ONES, 32'd50, 0);
    send_term_request(ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES, 0);
    send_term_request(PRIME - 32'd1, 32'd1, PRIME - 32'd1, PRIME - 32'd1, ALL_ONES, 0);
    send_term_request(32'd1, 32'd2, 32'd3, 32'd4, 32'h8000_0002, 0);
    send_term_request(32'd1, 32'd2, 32'd3, 32'd4, 32'h8000_0001, 0);
    send_term_request(PRIME_X2, PRIME_X3, 32'd1, 32'd1, 32'h5555_5557, 0);
    send_term_request(32'hAAAA_AAAA, 32'h5555_5555, 32'h1234_5678, 32'h8765_4321,
                      32'hAAAA_AAAC, 0);
  endtask

  task automatic test_random_terms(input int count, input int idle_pct);
    for (int i = 0; i < count; i++) begin
      send_term_request(pick_operand(), pick_operand(), pick_operand(), pick_operand(),
                        pick_index(), idle_pct);
    end
  endtask

  initial begin
    int drain_cycles;
    errors        = 0;
    drain_cycles  = 0;
    rst_ni        <= 1'b0;
    start         <= 1'b0;
    first_term_i  <= '0;
    second_term_i <= '0;
    coef_prev_i   <= '0;
    coef_prev2_i  <= '0;
    term_index_i  <= '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_low_indexes();
    test_operand_extremes();
    test_random_terms(500, 24);
    test_random_terms(500, 46);
    test_random_terms(500, 0);
    start <= 1'b0;

    while (pending_terms.size() != 0 && drain_cycles < 5000) begin
      @(posedge clk_i);
      drain_cycles++;
    end
    if (pending_terms.size() != 0) begin
      $error("term_value_o: %0d results never arrived", pending_terms.size());
      errors++;
    end
    repeat (50) @(posedge clk_i);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Well beyond the slowest correct run of all 1519 requested words.
  initial begin
    #250_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule

>>> linear_recurrence_mod_prime_unit.f
rtl/core/lrmp_pkg.sv
rtl/core/lrmp_mac_lane.sv
rtl/core/linear_recurrence_mod_prime_unit.sv
test/tb.sv
